>>> src/prp_pkg.sv
// shared types and constants for the prp list builder
package prp_pkg;

	// input item kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_PAGE  = 1'b1;

	// result item kinds
	localparam logic OUT_PAIR  = 1'b0;
	localparam logic OUT_ENTRY = 1'b1;

	// result queue geometry
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_SECOND = 2'd1,
		MODE_LIST   = 2'd2
	} mode_t;

	// compact result: a/b are prp_first/prp_second for a pair,
	// entry_addr/entry_value for a list entry write
	typedef struct packed {
		logic        kind;
		logic [63:0] a;
		logic [63:0] b;
		logic        last;
	} res_t;

endpackage

>>> src/prp_outq.sv
// result queue: up to two pushes and one pop per cycle
module prp_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push0,
	input  logic          push1,
	input  prp_pkg::res_t data0,
	input  prp_pkg::res_t data1,
	output logic          space2,
	output logic          out_valid,
	input  logic          out_ready,
	output prp_pkg::res_t head
);
	import prp_pkg::*;

	res_t                 mem_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]   wr_q;
	logic [OUTQ_AW-1:0]   rd_q;
	logic [OUTQ_CW-1:0]   count_q;
	logic [OUTQ_AW-1:0]   wr_next1;
	logic                 pop;

	assign pop       = out_valid & out_ready;
	assign out_valid = (count_q != '0);
	assign head      = mem_q[rd_q];
	assign space2    = (count_q <= OUTQ_CW'(OUTQ_DEPTH - 2));
	assign wr_next1  = wr_q + OUTQ_AW'(1);

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_q] <= data0;
		end
		if (push0 && push1) begin
			mem_q[wr_next1] <= data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + OUTQ_AW'(push0) + OUTQ_AW'(push0 & push1);
			rd_q    <= rd_q + OUTQ_AW'(pop);
			count_q <= count_q + OUTQ_CW'(push0) + OUTQ_CW'(push0 & push1) - OUTQ_CW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OUTQ_CW'(OUTQ_DEPTH))
		else $error("result queue overfilled");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push0 |-> space2)
		else $error("push without room for two results");
	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push0 |=> count_q == $past(count_q) - OUTQ_CW'(1))
		else $error("queue count wrong after pop");
`endif

endmodule

>>> src/prp_list_builder.sv
// prp list builder: pointer pair and list entry generation for one transfer
// results are registered in a four-entry result queue when their input is accepted
// throughput: one input item per cycle while ready is high, i.e. while the queue has two
// free; a chaining item yields two results, drained one per cycle while out_ready is high
// reset: arst_n sets idle mode and clears byte count, held page, list pointer, slot and queue
module prp_list_builder #(
	parameter int PAGE_BYTES      = 4096,
	parameter int LIST_DATA_SLOTS = 511
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [11:0] buf_offset,
	input  logic [20:0] transfer_bytes,
	input  logic [63:0] page_addr,
	input  logic [63:0] list_base,
	input  logic [63:0] next_list_page,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_kind,
	output logic [63:0] prp_first,
	output logic [63:0] prp_second,
	output logic [63:0] entry_addr,
	output logic [63:0] entry_value,
	output logic        last
);
	import prp_pkg::*;

	localparam logic [16:0] PB17      = 17'(PAGE_BYTES);
	localparam logic [20:0] PB21      = 21'(PAGE_BYTES);
	localparam logic [8:0]  LDS9      = 9'(LIST_DATA_SLOTS);
	localparam logic [63:0] CHAIN_OFS = 64'(LIST_DATA_SLOTS * 8);

	mode_t       mode_q, mode_d;
	logic [20:0] bl_q, bl_d;
	logic [63:0] held_q, held_d;
	logic [63:0] cur_q, cur_d;
	logic [8:0]  slot_q, slot_d;

	logic        acc;
	logic [16:0] off_mod;
	logic [16:0] cap;
	logic        fits;
	logic [20:0] rem;
	logic        chain;
	logic [8:0]  slot_eff;
	logic [20:0] bl_after;
	logic [63:0] chain_addr;
	logic [63:0] data_addr;
	logic        push0, push1;
	res_t        res0, res1;
	res_t        head;
	logic        space2;

	assign acc = in_valid & in_ready;

	// offset modulo page size, at most eight conditional subtracts
	always_comb begin
		off_mod = {5'b0, buf_offset};
		for (int i = 0; i < 8; i++) begin
			if (off_mod >= PB17) begin
				off_mod = off_mod - PB17;
			end
		end
	end

	assign cap      = PB17 - off_mod;
	assign fits     = (transfer_bytes <= {4'b0, cap});
	assign rem      = transfer_bytes - {4'b0, cap};
	assign chain    = (slot_q >= LDS9) && (bl_q > PB21);
	assign slot_eff = chain ? 9'd0 : slot_q;
	assign bl_after = (bl_q > PB21) ? (bl_q - PB21) : 21'd0;
	assign chain_addr = cur_q + CHAIN_OFS;
	assign data_addr  = (chain ? next_list_page : cur_q) + {52'b0, slot_eff, 3'b000};

	// next state
	always_comb begin
		mode_d = mode_q;
		bl_d   = bl_q;
		held_d = held_q;
		cur_d  = cur_q;
		slot_d = slot_q;
		if (acc) begin
			if (kind == KIND_START) begin
				if (fits) begin
					mode_d = MODE_IDLE;
					bl_d   = '0;
				end else begin
					bl_d   = rem;
					held_d = page_addr;
					slot_d = '0;
					if (rem <= PB21) begin
						mode_d = MODE_SECOND;
					end else begin
						mode_d = MODE_LIST;
						cur_d  = list_base;
					end
				end
			end else begin
				case (mode_q)
					MODE_SECOND: begin
						mode_d = MODE_IDLE;
						bl_d   = '0;
					end
					MODE_LIST: begin
						cur_d  = chain ? next_list_page : cur_q;
						slot_d = slot_eff + 9'd1;
						bl_d   = bl_after;
						if (bl_after == '0) begin
							mode_d = MODE_IDLE;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// results of the accepted transaction
	always_comb begin
		push0 = 1'b0;
		push1 = 1'b0;
		res0  = '{kind: OUT_PAIR, a: page_addr, b: 64'd0, last: 1'b1};
		res1  = '{kind: OUT_ENTRY, a: data_addr, b: page_addr, last: (bl_after == '0)};
		if (acc) begin
			if (kind == KIND_START) begin
				if (fits) begin
					push0 = 1'b1;
				end else if (rem > PB21) begin
					push0 = 1'b1;
					res0  = '{kind: OUT_PAIR, a: page_addr, b: list_base, last: 1'b0};
				end
			end else begin
				case (mode_q)
					MODE_SECOND: begin
						push0 = 1'b1;
						res0  = '{kind: OUT_PAIR, a: held_q, b: page_addr, last: 1'b1};
					end
					MODE_LIST: begin
						push0 = 1'b1;
						if (chain) begin
							push1 = 1'b1;
							res0  = '{kind: OUT_ENTRY, a: chain_addr, b: next_list_page,
								last: 1'b0};
						end else begin
							res0 = res1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			bl_q   <= '0;
			held_q <= '0;
			cur_q  <= '0;
			slot_q <= '0;
		end else begin
			mode_q <= mode_d;
			bl_q   <= bl_d;
			held_q <= held_d;
			cur_q  <= cur_d;
			slot_q <= slot_d;
		end
	end

	prp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (push0),
		.push1     (push1),
		.data0     (res0),
		.data1     (res1),
		.space2    (space2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign in_ready    = space2;
	assign out_kind    = head.kind;
	assign prp_first   = (head.kind == OUT_PAIR)  ? head.a : 64'd0;
	assign prp_second  = (head.kind == OUT_PAIR)  ? head.b : 64'd0;
	assign entry_addr  = (head.kind == OUT_ENTRY) ? head.a : 64'd0;
	assign entry_value = (head.kind == OUT_ENTRY) ? head.b : 64'd0;
	assign last        = head.last;

`ifndef SYNTHESIS
	a_idle_page_silent: assert property (@(posedge clk) disable iff (!arst_n)
		acc && kind == KIND_PAGE && mode_q != MODE_LIST && mode_q != MODE_SECOND
		|-> !push0)
		else $error("page transaction while idle produced a result");
	a_two_only_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		push1 |-> push0 && mode_q == MODE_LIST && kind == KIND_PAGE)
		else $error("second result outside list building");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		push0 && !push1 && res0.last |=> mode_q == MODE_IDLE)
		else $error("final result did not end the transfer");
`endif

endmodule

>>> dv/prp_list_builder_tb.sv
// self-checking testbench for the prp list builder: random and directed transfers
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import prp_pkg::*;

	localparam int PAGE_BYTES = 4096;
	localparam int LIST_SLOTS = 511;
	localparam int ITEM_GOAL  = 1400;

	typedef struct packed {
		logic        kind;
		logic [11:0] off;
		logic [20:0] len;
		logic [63:0] page;
		logic [63:0] base;
		logic [63:0] nxt;
		logic        drain_first;
	} xfer_item_t;

	typedef struct packed {
		logic        kind;
		logic [63:0] first;
		logic [63:0] second;
		logic [63:0] eaddr;
		logic [63:0] evalue;
		logic        last;
	} prp_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = 1'b0;
	logic [11:0] buf_offset = '0;
	logic [20:0] transfer_bytes = '0;
	logic [63:0] page_addr = '0;
	logic [63:0] list_base = '0;
	logic [63:0] next_list_page = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        out_kind;
	logic [63:0] prp_first;
	logic [63:0] prp_second;
	logic [63:0] entry_addr;
	logic [63:0] entry_value;
	logic        last;

	xfer_item_t  xfer_items[$];
	prp_result_t prp_expected[$];
	xfer_item_t  cur_item;
	int          n_accepted = 0;
	int          n_mismatch = 0;
	logic        rx_hold = 1'b0;
	logic        calm;

	// predicted block state
	mode_t       mode_q = MODE_IDLE;
	logic [20:0] remain = '0;
	logic [63:0] held_first = '0;
	logic [63:0] list_page = '0;
	logic [8:0]  slot = '0;

	prp_list_builder #(
		.PAGE_BYTES(PAGE_BYTES),
		.LIST_DATA_SLOTS(LIST_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.buf_offset(buf_offset),
		.transfer_bytes(transfer_bytes),
		.page_addr(page_addr),
		.list_base(list_base),
		.next_list_page(next_list_page),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_kind(out_kind),
		.prp_first(prp_first),
		.prp_second(prp_second),
		.entry_addr(entry_addr),
		.entry_value(entry_value),
		.last(last)
	);

	// no idling on either side for a stretch of the run
	assign calm = n_accepted >= 500 && n_accepted < 750;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic prp_result_t make_result(logic k, logic [63:0] a, logic [63:0] b,
			logic [63:0] ea, logic [63:0] ev, logic l);
		prp_result_t r;
		r.kind   = k;
		r.first  = a;
		r.second = b;
		r.eaddr  = ea;
		r.evalue = ev;
		r.last   = l;
		return r;
	endfunction

	function automatic void prp_predict(xfer_item_t it);
		int cap;
		if (it.kind == KIND_START) begin
			cap = PAGE_BYTES - (int'(it.off) % PAGE_BYTES);
			if (int'(it.len) <= cap) begin
				prp_expected.push_back(make_result(OUT_PAIR, it.page, '0, '0, '0, 1'b1));
				mode_q = MODE_IDLE;
				remain = '0;
			end else begin
				remain     = it.len - 21'(cap);
				held_first = it.page;
				slot       = '0;
				if (int'(remain) <= PAGE_BYTES) begin
					mode_q = MODE_SECOND;
				end else begin
					list_page = it.base;
					mode_q    = MODE_LIST;
					prp_expected.push_back(make_result(OUT_PAIR, it.page, it.base, '0, '0, 1'b0));
				end
			end
		end else if (mode_q == MODE_SECOND) begin
			prp_expected.push_back(make_result(OUT_PAIR, held_first, it.page, '0, '0, 1'b1));
			mode_q = MODE_IDLE;
			remain = '0;
		end else if (mode_q == MODE_LIST) begin
			// data slots full with more than one page to go: chain to the next list page
			if (int'(slot) >= LIST_SLOTS && int'(remain) > PAGE_BYTES) begin
				prp_expected.push_back(make_result(OUT_ENTRY, '0, '0,
					list_page + 64'(LIST_SLOTS) * 64'd8, it.nxt, 1'b0));
				list_page = it.nxt;
				slot      = '0;
			end
			remain = (int'(remain) > PAGE_BYTES) ? remain - 21'(PAGE_BYTES) : '0;
			prp_expected.push_back(make_result(OUT_ENTRY, '0, '0,
				list_page + {slot, 3'b000}, it.page, remain == '0));
			slot = slot + 9'd1;
			if (remain == '0)
				mode_q = MODE_IDLE;
		end
	endfunction

	task automatic add_item(logic k, logic [11:0] off, logic [20:0] len, logic [63:0] page,
			logic [63:0] base, logic drain);
		xfer_item_t it;
		it.kind        = k;
		it.off         = off;
		it.len         = len;
		it.page        = page;
		it.base        = base;
		it.nxt         = rand64();
		it.drain_first = drain;
		xfer_items.push_back(it);
	endtask

	// start-only fields carry noise on a page transaction
	task automatic add_page(logic [63:0] page);
		add_item(KIND_PAGE, 12'($urandom), 21'($urandom), page, rand64(), 1'b0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				prp_predict(cur_item);
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (xfer_items.size() > 0 && (calm || $urandom_range(99) >= 23) &&
						(!xfer_items[0].drain_first || prp_expected.size() == 0)) begin
					cur_item = xfer_items.pop_front();
					kind           <= cur_item.kind;
					buf_offset     <= cur_item.off;
					transfer_bytes <= cur_item.len;
					page_addr      <= cur_item.page;
					list_base      <= cur_item.base;
					next_list_page <= cur_item.nxt;
					in_valid       <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		prp_result_t want;
		prp_result_t got;
		logic        bad;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = make_result(out_kind, prp_first, prp_second, entry_addr, entry_value, last);
				if (prp_expected.size() == 0) begin
					want = '0;
					bad  = 1'b1;
				end else begin
					want = prp_expected.pop_front();
					bad  = got.kind !== want.kind || got.first !== want.first ||
						got.second !== want.second || got.eaddr !== want.eaddr ||
						got.evalue !== want.evalue || got.last !== want.last;
				end
				if (bad) begin
					if (n_mismatch < 10) begin
						$display("mismatch at %0t (expected %0d pending): kind %b/%b",
							$realtime, prp_expected.size(), want.kind, got.kind);
						$display("  first %h/%h second %h/%h",
							want.first, got.first, want.second, got.second);
						$display("  addr %h/%h value %h/%h last %b/%b",
							want.eaddr, got.eaddr, want.evalue, got.evalue,
							want.last, got.last);
					end
					n_mismatch++;
				end
			end
			out_ready <= !rx_hold && (calm || $urandom_range(99) >= 23);
		end
	end

	// long receiver stall so the result queue fills and input backs up
	initial begin
		while (n_accepted < 300)
			@(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#2_400_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int          sel;
		int          pages;
		int          cap;
		logic [11:0] off;
		logic        drain;
		bit          big_done;
		bit          drain_done;
		big_done   = 1'b0;
		drain_done = 1'b0;

		// directed
		add_page(rand64());
		add_item(KIND_START, 12'd0, 21'd0, '1, '0, 1'b0);
		add_item(KIND_START, 12'd0, 21'd4096, '0, '1, 1'b0);
		add_item(KIND_START, 12'hFFF, 21'd1, rand64(), rand64(), 1'b0);
		add_item(KIND_START, 12'hFFF, 21'd2, rand64(), rand64(), 1'b0);
		add_page('0);
		add_item(KIND_START, 12'd0, 21'd8192, rand64(), rand64(), 1'b0);
		add_page('1);
		// list base near the top so slot addresses wrap
		add_item(KIND_START, 12'd0, 21'd8193, rand64(), 64'hFFFF_FFFF_FFFF_FFF8, 1'b0);
		add_page(rand64());
		add_page(rand64());
		// new start drops an unfinished list transfer
		add_item(KIND_START, 12'd100, 21'd20000, rand64(), rand64(), 1'b0);
		add_page(rand64());
		add_item(KIND_START, 12'd0, 21'd4096, rand64(), rand64(), 1'b0);
		// new start while waiting for the second page
		add_item(KIND_START, 12'd0, 21'd5000, rand64(), rand64(), 1'b0);
		add_item(KIND_START, 12'd7, 21'd1, rand64(), rand64(), 1'b0);
		add_page(rand64());
		add_item(KIND_START, 12'd2048, 21'd2048, rand64(), rand64(), 1'b1);

		while (xfer_items.size() < ITEM_GOAL) begin
			drain = !drain_done && xfer_items.size() >= 1100;
			drain_done |= drain;
			off = ($urandom_range(7) == 0) ? 12'hFFF : 12'($urandom);
			cap = PAGE_BYTES - int'(off);
			sel = $urandom_range(99);
			if (!big_done && xfer_items.size() >= 700) begin
				// longest length the field holds: final page takes slot 511, where a chain pointer would go
				add_item(KIND_START, 12'hFFF, 21'h1FFFFF, rand64(), rand64(), drain);
				repeat (512) add_page(rand64());
				big_done = 1'b1;
			end else if (sel < 25) begin
				add_item(KIND_START, off, 21'($urandom_range(cap)), rand64(), rand64(), drain);
			end else if (sel < 45) begin
				add_item(KIND_START, off, 21'(cap + $urandom_range(PAGE_BYTES, 1)), rand64(),
					rand64(), drain);
				add_page(rand64());
			end else if (sel < 85) begin
				pages = $urandom_range(20, 3);
				add_item(KIND_START, off,
					21'(cap + (pages - 2) * PAGE_BYTES + $urandom_range(PAGE_BYTES, 1)),
					rand64(), rand64(), drain);
				repeat (pages - 1) add_page(rand64());
			end else if (sel < 93) begin
				// arbitrary length, usually cut short by the next start
				add_item(KIND_START, off, 21'($urandom), rand64(), rand64(), drain);
				repeat ($urandom_range(6)) add_page(rand64());
			end else begin
				add_page(rand64());
			end
		end

		while (!arst_n || xfer_items.size() != 0 || in_valid)
			@(posedge clk);
		while (prp_expected.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (n_mismatch == 0 && prp_expected.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> prp_list_builder.f
src/prp_pkg.sv
src/prp_outq.sv
src/prp_list_builder.sv
dv/prp_list_builder_tb.sv
